@@ rtl/core/wsha_pkg.sv @@
package wsha_pkg;

  // Binary angle thresholds, 65536 units per full turn.
  localparam logic [15:0] ANG_45  = 16'd8192;
  localparam logic [15:0] ANG_135 = 16'd24576;
  localparam logic [15:0] ANG_225 = 16'd40960;
  localparam logic [15:0] ANG_315 = 16'd57344;

  typedef struct packed {
    logic [15:0] angle;
    logic        last;
  } wsha_in_t;

  typedef struct packed {
    logic signed [15:0] mean_angle;
    logic               empty_list;
    logic               both_sides_discarded;
    logic               overflow;
  } wsha_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_DONE
  } wsha_state_t;

endpackage

@@ rtl/core/wrap_safe_heading_averager.sv @@
// Wrap-safe heading averager.
// Input channel in_valid/in_ready/in_data carries one binary angle per request,
// with a last flag closing the list. Each list produces exactly one request on
// out_valid/out_ready/out_data after its last angle is accepted.
// A non-final angle is absorbed while in_ready stays high, so the
// angles of a list can follow back to back.
// The final angle is accumulated, then the setup state picks the total with
// fewer discards and its kept count, and a restoring divider retires one
// quotient bit per cycle. The result then waits in the done state until it is
// loaded into the output register, which raises out_valid.
// in_ready stays low from the final angle until the result is loaded into the
// output register. If the receiver stalls, the result waits in the output
// register and the next list can already be accumulated; a second result waits
// in the divider until the output register frees up.
// Reset clears the totals, the counters and the output valid.
module wrap_safe_heading_averager #(
  parameter int MAX_HISTORY = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wsha_pkg::wsha_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wsha_pkg::wsha_out_t out_data
);

  localparam int CW = $clog2(MAX_HISTORY + 1);
  localparam int TW = 16 + CW;
  localparam int SW = $clog2(TW);

  wsha_pkg::wsha_state_t state_r, state_nxt;

  logic signed [TW-1:0] st_r, st_nxt;
  logic [TW-1:0]        ut_r, ut_nxt;
  logic [CW-1:0]        nh_r, nh_nxt;
  logic [CW-1:0]        nz_r, nz_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 ovf_r, ovf_nxt;

  logic [TW-1:0]        dvd_r, dvd_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [CW-1:0]        dvs_r, dvs_nxt;
  logic [SW-1:0]        step_r, step_nxt;
  logic                 neg_r, neg_nxt;
  logic                 empty_r, empty_nxt;
  logic                 both_r, both_nxt;

  wsha_pkg::wsha_out_t  out_data_r, out_data_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic in_acc, setup_en, div_en, out_load;
  logic near_zero, near_half, room;
  logic sel_signed;
  logic [CW-1:0] kept;
  logic [TW-1:0] mag;
  logic [CW:0]   shifted, diff;
  logic          ge;
  logic [15:0]   q16;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wsha_pkg::ST_IDLE:  if (in_acc && in_data.last) state_nxt = wsha_pkg::ST_SETUP;
      wsha_pkg::ST_SETUP: state_nxt = wsha_pkg::ST_DIV;
      wsha_pkg::ST_DIV:   if (step_r == '0) state_nxt = wsha_pkg::ST_DONE;
      wsha_pkg::ST_DONE:  if (!out_valid_r || out_ready) state_nxt = wsha_pkg::ST_IDLE;
      default:            state_nxt = wsha_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    setup_en = 1'b0;
    div_en   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      wsha_pkg::ST_IDLE:  in_ready = 1'b1;
      wsha_pkg::ST_SETUP: setup_en = 1'b1;
      wsha_pkg::ST_DIV:   div_en = 1'b1;
      wsha_pkg::ST_DONE:  out_load = !out_valid_r || out_ready;
      default:            in_ready = 1'b0;
    endcase
  end

  assign in_acc = in_valid && in_ready;

  // Angle classification; the near-zero window is -45..45 degrees in the signed view.
  assign near_zero = (in_data.angle < wsha_pkg::ANG_45) || (in_data.angle > wsha_pkg::ANG_315);
  assign near_half = (in_data.angle > wsha_pkg::ANG_135) && (in_data.angle < wsha_pkg::ANG_225);
  assign room      = cnt_r < CW'(MAX_HISTORY);

  // Ties go to the unsigned total.
  assign sel_signed = nh_r < nz_r;
  assign kept       = sel_signed ? (cnt_r - nh_r) : (cnt_r - nz_r);
  assign mag        = (sel_signed && st_r[TW-1]) ? TW'(~st_r + 1'b1) : (sel_signed ? st_r : ut_r);

  // Restoring divider step, one quotient bit per cycle.
  assign shifted = {rem_r, dvd_r[TW-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign q16     = dvd_r[15:0];

  always_comb begin
    st_nxt    = st_r;
    ut_nxt    = ut_r;
    nh_nxt    = nh_r;
    nz_nxt    = nz_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    step_nxt  = step_r;
    neg_nxt   = neg_r;
    empty_nxt = empty_r;
    both_nxt  = both_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (in_acc) begin
      if (room) begin
        if (near_zero) nz_nxt = nz_r + 1'b1;
        else           ut_nxt = ut_r + TW'(in_data.angle);
        if (near_half) nh_nxt = nh_r + 1'b1;
        else           st_nxt = st_r + {{(TW-16){in_data.angle[15]}}, in_data.angle};
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (setup_en) begin
      dvd_nxt   = mag;
      rem_nxt   = '0;
      dvs_nxt   = kept;
      step_nxt  = SW'(TW - 1);
      neg_nxt   = sel_signed && st_r[TW-1];
      empty_nxt = kept == '0;
      both_nxt  = (nh_r != '0) && (nz_r != '0);
    end

    if (div_en) begin
      rem_nxt  = ge ? diff[CW-1:0] : shifted[CW-1:0];
      dvd_nxt  = {dvd_r[TW-2:0], ge};
      step_nxt = step_r - 1'b1;
    end

    if (out_load) begin
      out_data_nxt.mean_angle           = empty_r ? 16'sd0 : (neg_r ? -q16 : q16);
      out_data_nxt.empty_list           = empty_r;
      out_data_nxt.both_sides_discarded = both_r;
      out_data_nxt.overflow             = ovf_r;
      out_valid_nxt = 1'b1;
      // The list is finished; start the next one from scratch.
      st_nxt  = '0;
      ut_nxt  = '0;
      nh_nxt  = '0;
      nz_nxt  = '0;
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wsha_pkg::ST_IDLE;
      st_r        <= '0;
      ut_r        <= '0;
      nh_r        <= '0;
      nz_r        <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      ut_r        <= ut_nxt;
      nh_r        <= nh_nxt;
      nz_r        <= nz_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    step_r     <= step_nxt;
    neg_r      <= neg_nxt;
    empty_r    <= empty_nxt;
    both_r     <= both_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_HISTORY))
    else $error("item count exceeds history bound");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_list |-> out_data.mean_angle == 16'sd0)
    else $error("empty list with nonzero mean");

  a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> cnt_r == '0 && nh_r == '0 && nz_r == '0 && !ovf_r)
    else $error("list state not cleared after result");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == wsha_pkg::ST_DIV && step_r == '0 |=> state_r == wsha_pkg::ST_DONE)
    else $error("divider did not finish on last step");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == wsha_pkg::ST_SETUP |-> !in_ready && $past(in_acc && in_data.last))
    else $error("setup entered without a final angle");
`endif

endmodule
